/* src/stv_pkg.sv */
// ----------------------------------------------------------------------------
// stv_pkg
// Shared types and constants of the Steiner topology decoder: store depths,
// field types and the command and status words between controller and
// datapath.
// ----------------------------------------------------------------------------
`default_nettype none

package stv_pkg;

  // store depths
  localparam int unsigned SplitSlots   = 29;
  localparam int unsigned EdgeSlots    = 61;
  localparam int unsigned SteinerSlots = 30;

  // first path levels that seed the three root edges
  localparam logic [4:0] SeedLevelMax = 5'd2;
  localparam logic [4:0] SplitLevelMin = 5'd3;
  localparam logic [5:0] SeedEdges    = 6'd3;

  // site count register
  localparam logic [5:0] SiteCountReset = 6'd32;
  localparam logic [5:0] MinSites       = 6'd3;

  // a Steiner point has three neighbours
  localparam logic [1:0] FillMax = 2'd3;

  typedef logic [5:0] vid_t;   // vertex id, also edge index
  typedef logic [4:0] lvl_t;   // path level, Steiner row

  // commands from the controller, at most one per cycle
  typedef struct packed {
    logic load;        // take an input word
    logic path_rd;     // fetch first split step
    logic build_a;     // read split edge, write first new edge
    logic build_b;     // retarget split edge, write start of the other new edge
    logic build_c;     // finish the other new edge, fetch next split step
    logic walk_init;   // clear neighbour counts, fetch edge 0
    logic place_a;     // place far end at first end
    logic place_b;     // place first end at far end, fetch next edge
    logic emit_rd;     // fetch neighbour row
    logic emit_load;   // load output register
  } cmd_t;

  // status back to the controller
  typedef struct packed {
    logic start_run;   // input word is a last item deep enough to decode
    logic no_steps;    // path has no split levels
    logic build_last;  // current split step is the last one
    logic walk_last;   // current edge is the last one
    logic emit_last;   // current row is the last one
    logic out_free;    // output register can take a word
  } status_t;

endpackage

`default_nettype wire

/* src/stv_ctrl.sv */
// ----------------------------------------------------------------------------
// stv_ctrl
// Sequencer of the decoder: loads path words, then steps the edge build,
// the edge list walk and the row emission through the datapath.
// ----------------------------------------------------------------------------
`default_nettype none

module stv_ctrl (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_stall_o,
  input  stv_pkg::status_t status_i,
  output stv_pkg::cmd_t    cmd_o
);

  typedef enum logic [9:0] {
    ST_IDLE    = 10'b00_0000_0001,
    ST_PATH    = 10'b00_0000_0010,
    ST_SPLIT   = 10'b00_0000_0100,
    ST_LINK    = 10'b00_0000_1000,
    ST_TAIL    = 10'b00_0001_0000,
    ST_CLEAR   = 10'b00_0010_0000,
    ST_PLACE_A = 10'b00_0100_0000,
    ST_PLACE_B = 10'b00_1000_0000,
    ST_FETCH   = 10'b01_0000_0000,
    ST_SEND    = 10'b10_0000_0000
  } state_e;

  state_e state_q, state_d;

  // state register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // input side only open while idle
  assign in_stall_o = (state_q != ST_IDLE);

  // next state and commands
  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          if (status_i.start_run) begin
            state_d = status_i.no_steps ? ST_CLEAR : ST_PATH;
          end
        end
      end
      ST_PATH: begin
        cmd_o.path_rd = 1'b1;
        state_d       = ST_SPLIT;
      end
      ST_SPLIT: begin
        cmd_o.build_a = 1'b1;
        state_d       = ST_LINK;
      end
      ST_LINK: begin
        cmd_o.build_b = 1'b1;
        state_d       = ST_TAIL;
      end
      ST_TAIL: begin
        cmd_o.build_c = 1'b1;
        state_d       = status_i.build_last ? ST_CLEAR : ST_SPLIT;
      end
      ST_CLEAR: begin
        cmd_o.walk_init = 1'b1;
        state_d         = ST_PLACE_A;
      end
      ST_PLACE_A: begin
        cmd_o.place_a = 1'b1;
        state_d       = ST_PLACE_B;
      end
      ST_PLACE_B: begin
        cmd_o.place_b = 1'b1;
        state_d       = status_i.walk_last ? ST_FETCH : ST_PLACE_A;
      end
      ST_FETCH: begin
        cmd_o.emit_rd = 1'b1;
        state_d       = ST_SEND;
      end
      ST_SEND: begin
        if (status_i.out_free) begin
          cmd_o.emit_load = 1'b1;
          state_d         = status_i.emit_last ? ST_IDLE : ST_FETCH;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

endmodule

`default_nettype wire

/* src/stv_dpath.sv */
// ----------------------------------------------------------------------------
// stv_dpath
// Datapath of the decoder: site count register, path store, edge list,
// neighbour counts and rows, run counters and the output register.
// ----------------------------------------------------------------------------
`default_nettype none

module stv_dpath #(
  parameter int unsigned MAX_SITES = 32
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             cfg_we_i,
  input  logic [5:0]       cfg_wdata_i,
  input  logic [4:0]       level_i,
  input  logic [5:0]       edge_split_i,
  input  logic [4:0]       site_i,
  input  logic             last_item_i,
  input  stv_pkg::cmd_t    cmd_i,
  output stv_pkg::status_t status_o,
  input  logic             out_stall_i,
  output logic             out_valid_o,
  output logic [4:0]       steiner_index_o,
  output logic [5:0]       neighbour_a_o,
  output logic [5:0]       neighbour_b_o,
  output logic [5:0]       neighbour_c_o,
  output logic [4:0]       steiner_total_o,
  output logic             last_result_o
);

  localparam logic [5:0] MaxSites = 6'(MAX_SITES);

  // site count register and clamped site count
  logic [5:0]    site_count_q;
  stv_pkg::vid_t n_eff;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      site_count_q <= stv_pkg::SiteCountReset;
    end else if (cfg_we_i) begin
      site_count_q <= cfg_wdata_i;
    end
  end

  always_comb begin
    if (site_count_q < stv_pkg::MinSites) begin
      n_eff = stv_pkg::MinSites;
    end else if (site_count_q > MaxSites) begin
      n_eff = MaxSites;
    end else begin
      n_eff = site_count_q;
    end
  end

  // run counters
  stv_pkg::lvl_t total_q;     // Steiner points of this run
  stv_pkg::lvl_t steps_m1_q;  // split steps minus one
  stv_pkg::lvl_t step_q;      // current split step
  stv_pkg::vid_t edges_q;     // edges built so far
  stv_pkg::vid_t walk_q;      // edge under walk
  stv_pkg::lvl_t row_q;       // row under emission
  stv_pkg::vid_t split_q;     // saturated split edge of this step

  logic seed_lvl;
  logic start_run;

  assign seed_lvl  = (level_i <= stv_pkg::SeedLevelMax);
  assign start_run = last_item_i && (level_i >= stv_pkg::SeedLevelMax);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      total_q    <= '0;
      steps_m1_q <= '0;
      step_q     <= '0;
      edges_q    <= '0;
      walk_q     <= '0;
      row_q      <= '0;
    end else begin
      if (cmd_i.load && start_run) begin
        total_q    <= level_i - 5'd1;
        steps_m1_q <= level_i - stv_pkg::SplitLevelMin;
        step_q     <= '0;
        edges_q    <= stv_pkg::SeedEdges;
      end
      if (cmd_i.build_c) begin
        step_q  <= step_q + 5'd1;
        edges_q <= edges_q + 6'd2;
      end
      if (cmd_i.walk_init) begin
        walk_q <= '0;
        row_q  <= '0;
      end
      if (cmd_i.place_b) begin
        walk_q <= walk_q + 6'd1;
      end
      if (cmd_i.emit_load) begin
        row_q <= row_q + 5'd1;
      end
    end
  end

  // path store: split edge and site of levels from three on
  logic [5:0]    split_mem [stv_pkg::SplitSlots];
  logic [4:0]    site_mem  [stv_pkg::SplitSlots];
  logic [5:0]    split_rd_q;
  logic [4:0]    site_rd_q;
  logic          path_re;
  stv_pkg::lvl_t path_raddr;
  stv_pkg::lvl_t path_waddr;

  assign path_waddr = level_i - stv_pkg::SplitLevelMin;
  assign path_re    = cmd_i.path_rd || (cmd_i.build_c && !status_o.build_last);
  assign path_raddr = cmd_i.build_c ? (step_q + 5'd1) : step_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.load && !seed_lvl) begin
      split_mem[path_waddr] <= edge_split_i;
      site_mem[path_waddr]  <= site_i;
    end
    if (path_re) begin
      split_rd_q <= split_mem[path_raddr];
      site_rd_q  <= site_mem[path_raddr];
    end
  end

  // edge list, first and second ends in separate arrays
  stv_pkg::vid_t end0_mem [stv_pkg::EdgeSlots];
  stv_pkg::vid_t end1_mem [stv_pkg::EdgeSlots];
  stv_pkg::vid_t end0_rd_q, end1_rd_q;
  stv_pkg::vid_t steiner_id, edges_p1, split_sat;
  logic          end0_we, end1_we, edge_re;
  stv_pkg::vid_t end0_waddr, end0_wdata, end1_waddr, end1_wdata, edge_raddr;

  assign steiner_id = n_eff + 6'd1 + {1'b0, step_q};
  assign edges_p1   = edges_q + 6'd1;
  assign split_sat  = (split_rd_q >= edges_q) ? (edges_q - 6'd1) : split_rd_q;

  // edge write ports
  always_comb begin
    end0_we    = 1'b0;
    end0_waddr = '0;
    end0_wdata = '0;
    end1_we    = 1'b0;
    end1_waddr = '0;
    end1_wdata = '0;
    if (cmd_i.load && seed_lvl) begin
      end0_we    = 1'b1;
      end0_waddr = 6'(level_i);
      end0_wdata = {1'b0, site_i};
      end1_we    = 1'b1;
      end1_waddr = 6'(level_i);
      end1_wdata = n_eff;
    end else if (cmd_i.build_a) begin
      end0_we    = 1'b1;
      end0_waddr = edges_q;
      end0_wdata = {1'b0, site_rd_q};
      end1_we    = 1'b1;
      end1_waddr = edges_q;
      end1_wdata = steiner_id;
    end else if (cmd_i.build_b) begin
      end0_we    = 1'b1;
      end0_waddr = edges_p1;
      end0_wdata = end1_rd_q;
      end1_we    = 1'b1;
      end1_waddr = split_q;
      end1_wdata = steiner_id;
    end else if (cmd_i.build_c) begin
      end1_we    = 1'b1;
      end1_waddr = edges_p1;
      end1_wdata = steiner_id;
    end
  end

  // edge read port, shared by build and walk
  always_comb begin
    edge_re    = 1'b0;
    edge_raddr = '0;
    if (cmd_i.build_a) begin
      edge_re    = 1'b1;
      edge_raddr = split_sat;
    end else if (cmd_i.walk_init) begin
      edge_re    = 1'b1;
      edge_raddr = '0;
    end else if (cmd_i.place_b && !status_o.walk_last) begin
      edge_re    = 1'b1;
      edge_raddr = walk_q + 6'd1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (end0_we) begin
      end0_mem[end0_waddr] <= end0_wdata;
    end
    if (end1_we) begin
      end1_mem[end1_waddr] <= end1_wdata;
    end
    if (edge_re) begin
      end0_rd_q <= end0_mem[edge_raddr];
      end1_rd_q <= end1_mem[edge_raddr];
    end
    if (cmd_i.build_a) begin
      split_q <= split_sat;
    end
  end

  // neighbour placement
  logic [1:0]    fill_q [stv_pkg::SteinerSlots];
  stv_pkg::vid_t vertex, other, row_full;
  stv_pkg::lvl_t fill_idx;
  logic [1:0]    fill_cur;
  logic          place_ok;

  always_comb begin
    vertex   = cmd_i.place_a ? end0_rd_q : end1_rd_q;
    other    = cmd_i.place_a ? end1_rd_q : end0_rd_q;
    row_full = vertex - n_eff;
    fill_idx = cmd_i.emit_load ? row_q : row_full[4:0];
    fill_cur = (fill_idx < 5'(stv_pkg::SteinerSlots)) ? fill_q[fill_idx] : '0;
    place_ok = (cmd_i.place_a || cmd_i.place_b) && (vertex >= n_eff) &&
               (row_full < 6'(stv_pkg::SteinerSlots)) && (fill_cur != stv_pkg::FillMax);
  end

  // neighbour counts, cleared at the start of every walk
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int r = 0; r < stv_pkg::SteinerSlots; r++) begin
        fill_q[r] <= '0;
      end
    end else if (cmd_i.walk_init) begin
      for (int r = 0; r < stv_pkg::SteinerSlots; r++) begin
        fill_q[r] <= '0;
      end
    end else if (place_ok) begin
      fill_q[row_full[4:0]] <= fill_cur + 2'd1;
    end
  end

  // neighbour rows, one array per slot
  stv_pkg::vid_t slot_a_mem [stv_pkg::SteinerSlots];
  stv_pkg::vid_t slot_b_mem [stv_pkg::SteinerSlots];
  stv_pkg::vid_t slot_c_mem [stv_pkg::SteinerSlots];
  stv_pkg::vid_t slot_a_rd_q, slot_b_rd_q, slot_c_rd_q;

  always_ff @(posedge clk_i) begin
    if (place_ok) begin
      case (fill_cur)
        2'd0:    slot_a_mem[row_full[4:0]] <= other;
        2'd1:    slot_b_mem[row_full[4:0]] <= other;
        default: slot_c_mem[row_full[4:0]] <= other;
      endcase
    end
    if (cmd_i.emit_rd) begin
      slot_a_rd_q <= slot_a_mem[row_q];
      slot_b_rd_q <= slot_b_mem[row_q];
      slot_c_rd_q <= slot_c_mem[row_q];
    end
  end

  // output register
  logic          out_valid_q;
  stv_pkg::lvl_t out_index_q, out_total_q;
  stv_pkg::vid_t out_a_q, out_b_q, out_c_q;
  logic          out_last_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.emit_load) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  // slots never filled in this run read zero
  always_ff @(posedge clk_i) begin
    if (cmd_i.emit_load) begin
      out_index_q <= row_q;
      out_a_q     <= (fill_cur >= 2'd1) ? slot_a_rd_q : '0;
      out_b_q     <= (fill_cur >= 2'd2) ? slot_b_rd_q : '0;
      out_c_q     <= (fill_cur == stv_pkg::FillMax) ? slot_c_rd_q : '0;
      out_total_q <= total_q;
      out_last_q  <= status_o.emit_last;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign steiner_index_o = out_index_q;
  assign neighbour_a_o   = out_a_q;
  assign neighbour_b_o   = out_b_q;
  assign neighbour_c_o   = out_c_q;
  assign steiner_total_o = out_total_q;
  assign last_result_o   = out_last_q;

  // status
  assign status_o.start_run  = start_run;
  assign status_o.no_steps   = (level_i == stv_pkg::SeedLevelMax);
  assign status_o.build_last = (step_q == steps_m1_q);
  assign status_o.walk_last  = (walk_q == (edges_q - 6'd1));
  assign status_o.emit_last  = (row_q == (total_q - 5'd1));
  assign status_o.out_free   = !out_valid_q || !out_stall_i;

endmodule

`default_nettype wire

/* src/steiner_topology_from_split_vector.sv */
// ----------------------------------------------------------------------------
// steiner_topology_from_split_vector
// Rebuilds a full Steiner topology from one enumeration path and gives the
// three neighbours of every Steiner point.
//
//   channel  direction  handshake                 word
//   cfg      in         cfg_we_i                  site count
//   in       in         in_valid_i / in_stall_o   one path level
//   out      out        out_valid_o / out_stall_i one Steiner point row
//
// A last word at depth L (L >= 2) starts a run: the edge list is built split
// step by split step, then walked edge by edge, then one row is emitted per
// Steiner point, with output stalls holding the emission. The walk places
// both ends of every edge one after the other into the neighbour rows, one
// write a cycle. The input is stalled during a run and open again once the
// last row sits in the output register.
// Reset sets the site count to 32 and clears the neighbour counts; the
// stores hold nothing meaningful until written.
// ----------------------------------------------------------------------------
`default_nettype none

module steiner_topology_from_split_vector #(
  parameter int unsigned MAX_SITES = 32
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       cfg_we_i,
  input  logic [5:0] cfg_wdata_i,
  input  logic       in_valid_i,
  output logic       in_stall_o,
  input  logic [4:0] level_i,
  input  logic [5:0] edge_split_i,
  input  logic [4:0] site_i,
  input  logic       last_item_i,
  output logic       out_valid_o,
  input  logic       out_stall_i,
  output logic [4:0] steiner_index_o,
  output logic [5:0] neighbour_a_o,
  output logic [5:0] neighbour_b_o,
  output logic [5:0] neighbour_c_o,
  output logic [4:0] steiner_total_o,
  output logic       last_result_o
);

  stv_pkg::cmd_t    cmd;
  stv_pkg::status_t status;

  // sequencer
  stv_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  // stores, counters and output register
  stv_dpath #(
    .MAX_SITES (MAX_SITES)
  ) u_dpath (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_we_i        (cfg_we_i),
    .cfg_wdata_i     (cfg_wdata_i),
    .level_i         (level_i),
    .edge_split_i    (edge_split_i),
    .site_i          (site_i),
    .last_item_i     (last_item_i),
    .cmd_i           (cmd),
    .status_o        (status),
    .out_stall_i     (out_stall_i),
    .out_valid_o     (out_valid_o),
    .steiner_index_o (steiner_index_o),
    .neighbour_a_o   (neighbour_a_o),
    .neighbour_b_o   (neighbour_b_o),
    .neighbour_c_o   (neighbour_c_o),
    .steiner_total_o (steiner_total_o),
    .last_result_o   (last_result_o)
  );

`ifndef ASSERT_OFF
  // a word that starts a run closes the input side
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o && last_item_i && (level_i >= 5'd2)) |=> in_stall_o)
    else $error("input not stalled after run start");

  // the last row carries the highest Steiner index
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && last_result_o) |-> (steiner_index_o == (steiner_total_o - 5'd1)))
    else $error("last row index does not match total");

  // the sequencer issues at most one command per cycle
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot0(cmd))
    else $error("more than one datapath command");
`endif

endmodule

`default_nettype wire

/* tb/testbench.sv */
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the Steiner topology decoder. Path words are sent
// in random bursts. A built-in predictor rebuilds the edge list on every
// last word of level two or more and queues one row per Steiner point. Each row the block sends
// is checked against the oldest queued row. The site count is changed
// between phases, only while the block is idle.
// ----------------------------------------------------------------------------
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned MaxSites    = 32;
  // covers the longest run, at depth 31, plus margin
  localparam int unsigned DrainCycles = 320;
  // slowest run: ~60 decodes of up to 30 rows under heavy stall, far below this
  localparam int unsigned CycleLimit  = 400000;
  localparam int unsigned PhaseWords  = 42;

  // one path level as sent on the input channel
  typedef struct packed {
    stv_pkg::lvl_t level;
    stv_pkg::vid_t edge_split;
    logic [4:0]    site;
    logic          last_item;
  } path_word_t;

  // one Steiner point row as sent on the output channel
  typedef struct packed {
    stv_pkg::lvl_t row_index;
    stv_pkg::vid_t nbr_a;
    stv_pkg::vid_t nbr_b;
    stv_pkg::vid_t nbr_c;
    stv_pkg::lvl_t total;
    logic          last_row;
  } steiner_row_t;

  logic       clk_i       = 1'b0;
  logic       rst_ni      = 1'b0;
  logic       cfg_we_i    = 1'b0;
  logic [5:0] cfg_wdata_i = 6'd0;
  logic       in_valid_i  = 1'b0;
  logic       in_stall_o;
  logic [4:0] level_i      = 5'd0;
  logic [5:0] edge_split_i = 6'd0;
  logic [4:0] site_i       = 5'd0;
  logic       last_item_i  = 1'b0;
  logic       out_valid_o;
  logic       out_stall_i  = 1'b0;
  logic [4:0] steiner_index_o;
  logic [5:0] neighbour_a_o;
  logic [5:0] neighbour_b_o;
  logic [5:0] neighbour_c_o;
  logic [4:0] steiner_total_o;
  logic       last_result_o;

  steiner_topology_from_split_vector #(
    .MAX_SITES(MaxSites)
  ) dut (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_wdata_i,
    .in_valid_i, .in_stall_o, .level_i, .edge_split_i, .site_i, .last_item_i,
    .out_valid_o, .out_stall_i, .steiner_index_o, .neighbour_a_o,
    .neighbour_b_o, .neighbour_c_o, .steiner_total_o, .last_result_o
  );

  // predictor state
  logic [5:0]    site_count_q = stv_pkg::SiteCountReset;
  stv_pkg::vid_t split_lvl [stv_pkg::SplitSlots];
  logic [4:0]    site_lvl [stv_pkg::SplitSlots];
  stv_pkg::vid_t edge_tail [stv_pkg::EdgeSlots];
  stv_pkg::vid_t edge_head [stv_pkg::EdgeSlots];
  logic [1:0]    row_fill [stv_pkg::SteinerSlots];
  stv_pkg::vid_t row_nbr [stv_pkg::SteinerSlots][3];
  steiner_row_t  rows_due [$];

  // stimulus and bookkeeping
  path_word_t   pending_words [$];
  path_word_t   next_word;
  bit           level_seen [32];
  int unsigned  words_queued  = 0;
  int unsigned  words_taken   = 0;
  int unsigned  mismatch_count = 0;
  int unsigned  cycle_count   = 0;
  bit           word_taken    = 1'b0;
  int unsigned  burst_left    = 1;
  int unsigned  gap_left      = 0;
  logic [31:0]  stall_tick    = 0;
  int unsigned  hold_left     = 0;
  bit           hold_done     = 1'b0;
  logic [5:0]   cfg_plan [6]  = '{6'd3, 6'd63, 6'd0, 6'd32, 6'd17, 6'd0};

  // clock
  always #1 clk_i = ~clk_i;

  // give a vertex one more neighbour, Steiner rows only, three at most
  task automatic attach_neighbour(input stv_pkg::vid_t vertex,
                                  input stv_pkg::vid_t other,
                                  input int unsigned n);
    int unsigned row;
    if (vertex < n) return;
    row = vertex - n;
    if (row >= stv_pkg::SteinerSlots) return;
    if (row_fill[row] >= stv_pkg::FillMax) return;
    row_nbr[row][row_fill[row]] = other;
    row_fill[row] = row_fill[row] + 2'd1;
  endtask

  // store one path word; on a last word of level two or more rebuild the topology and queue its rows
  task automatic decode_word(input path_word_t w);
    int unsigned n, e, s, nxt, k, total;
    stv_pkg::vid_t far_end;
    steiner_row_t row;
    n = site_count_q;
    if (n < stv_pkg::MinSites) n = stv_pkg::MinSites;
    if (n > MaxSites) n = MaxSites;
    if (w.level <= stv_pkg::SeedLevelMax) begin
      edge_tail[w.level] = stv_pkg::vid_t'(w.site);
      edge_head[w.level] = stv_pkg::vid_t'(n);
    end else begin
      split_lvl[w.level - stv_pkg::SplitLevelMin] = w.edge_split;
      site_lvl[w.level - stv_pkg::SplitLevelMin] = w.site;
    end
    if (!w.last_item || w.level < stv_pkg::SeedLevelMax) return;
    // split edges, one new Steiner point per level from 3 on
    e = stv_pkg::SeedEdges;
    nxt = n + 1;
    for (k = 0; k + 2 < w.level; k++) begin
      s = split_lvl[k];
      if (s >= e) s = e - 1;
      far_end = edge_head[s];
      edge_tail[e] = stv_pkg::vid_t'(site_lvl[k]);
      edge_head[e] = stv_pkg::vid_t'(nxt);
      e++;
      edge_tail[e] = far_end;
      edge_head[e] = stv_pkg::vid_t'(nxt);
      e++;
      edge_head[s] = stv_pkg::vid_t'(nxt);
      nxt++;
    end
    // walk the edge list in order
    for (k = 0; k < stv_pkg::SteinerSlots; k++) begin
      row_fill[k] = '0;
      row_nbr[k][0] = '0;
      row_nbr[k][1] = '0;
      row_nbr[k][2] = '0;
    end
    for (k = 0; k < e; k++) begin
      attach_neighbour(edge_tail[k], edge_head[k], n);
      attach_neighbour(edge_head[k], edge_tail[k], n);
    end
    total = w.level - 1;
    for (k = 0; k < total; k++) begin
      row.row_index = stv_pkg::lvl_t'(k);
      row.nbr_a = row_nbr[k][0];
      row.nbr_b = row_nbr[k][1];
      row.nbr_c = row_nbr[k][2];
      row.total = stv_pkg::lvl_t'(total);
      row.last_row = (k + 1 == total);
      rows_due.push_back(row);
    end
  endtask

  // queue one word; its last flag is kept only when every level it reads was written, or below level two
  task automatic push_word(input int unsigned lvl, input int unsigned split,
                           input int unsigned site, input bit last);
    path_word_t w;
    bit complete;
    level_seen[lvl] = 1'b1;
    complete = 1'b1;
    for (int k = 0; k <= lvl; k++) begin
      if (!level_seen[k]) complete = 1'b0;
    end
    w.level = stv_pkg::lvl_t'(lvl);
    w.edge_split = stv_pkg::vid_t'(split);
    w.site = 5'(site);
    w.last_item = last && (complete || lvl < stv_pkg::SeedLevelMax);
    pending_words.push_back(w);
    words_queued++;
  endtask

  // well-formed path, root to depth, mostly in-range splits
  task automatic push_path(input int unsigned depth);
    int unsigned lv, split;
    for (lv = 0; lv <= depth; lv++) begin
      split = (lv >= stv_pkg::SplitLevelMin && $urandom_range(0, 7) != 0) ?
              $urandom_range(0, 2 * lv - 4) : $urandom_range(0, 63);
      push_word(lv, split, $urandom_range(0, 31), lv == depth);
    end
  endtask

  // random mix of paths, broken paths and stray words
  task automatic run_phase(input int unsigned words, input bit deep_first);
    int unsigned start, pick, depth, stop, lv;
    start = words_queued;
    if (deep_first) push_path(31);
    while (words_queued - start < words) begin
      pick = $urandom_range(0, 9);
      if (pick < 7) begin
        depth = ($urandom_range(0, 19) == 0) ? $urandom_range(26, 31) :
                $urandom_range(2, 9);
        push_path(depth);
      end else if (pick == 7) begin
        // path cut short, sometimes with a level sent twice
        depth = $urandom_range(3, 12);
        stop = $urandom_range(1, depth);
        for (lv = 0; lv < stop; lv++) begin
          push_word(lv, $urandom_range(0, 63), $urandom_range(0, 31), 1'b0);
          if ($urandom_range(0, 5) == 0)
            push_word(lv, $urandom_range(0, 63), $urandom_range(0, 31), 1'b0);
        end
      end else begin
        push_word($urandom_range(0, 31), $urandom_range(0, 63),
                  $urandom_range(0, 31), $urandom_range(0, 6) == 0);
      end
    end
  endtask

  // wait for all words taken and all rows back, then let the block go quiet
  task automatic settle();
    while (pending_words.size() != 0 || in_valid_i || rows_due.size() != 0)
      @(posedge clk_i);
    repeat (DrainCycles) @(negedge clk_i);
  endtask

  // sample both channels and the config port
  always @(posedge clk_i) begin
    steiner_row_t got, exp_row;
    if (rst_ni) begin
      if (cfg_we_i) site_count_q = cfg_wdata_i;
      if (out_valid_o && !out_stall_i) begin
        got.row_index = steiner_index_o;
        got.nbr_a = neighbour_a_o;
        got.nbr_b = neighbour_b_o;
        got.nbr_c = neighbour_c_o;
        got.total = steiner_total_o;
        got.last_row = last_result_o;
        if (rows_due.size() == 0) begin
          mismatch_count++;
          $display("%0t unexpected row: idx %0d nbrs %0d %0d %0d total %0d last %0b",
                   $time, got.row_index, got.nbr_a, got.nbr_b, got.nbr_c,
                   got.total, got.last_row);
        end else begin
          exp_row = rows_due.pop_front();
          if (got !== exp_row) begin
            mismatch_count++;
            $display("%0t mismatch: expected idx %0d nbrs %0d %0d %0d total %0d last %0b",
                     $time, exp_row.row_index, exp_row.nbr_a, exp_row.nbr_b,
                     exp_row.nbr_c, exp_row.total, exp_row.last_row);
            $display("%0t            actual   idx %0d nbrs %0d %0d %0d total %0d last %0b",
                     $time, got.row_index, got.nbr_a, got.nbr_b, got.nbr_c,
                     got.total, got.last_row);
          end
        end
      end
      word_taken = in_valid_i && !in_stall_o;
      if (word_taken) begin
        next_word.level = level_i;
        next_word.edge_split = edge_split_i;
        next_word.site = site_i;
        next_word.last_item = last_item_i;
        decode_word(next_word);
        words_taken++;
      end
    end else begin
      word_taken = 1'b0;
    end
  end

  // sender: bursts of words with random gaps
  always @(negedge clk_i) begin
    if (rst_ni && (!in_valid_i || word_taken)) begin
      if (gap_left > 0 || pending_words.size() == 0) begin
        if (gap_left > 0) gap_left--;
        in_valid_i <= 1'b0;
      end else begin
        next_word = pending_words.pop_front();
        level_i <= next_word.level;
        edge_split_i <= next_word.edge_split;
        site_i <= next_word.site;
        last_item_i <= next_word.last_item;
        in_valid_i <= 1'b1;
        if (burst_left > 1) begin
          burst_left--;
        end else begin
          burst_left = $urandom_range(1, 24);
          gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 5);
        end
      end
    end
  end

  // receiver: stall pattern steps through four modes on bits 8:7 of a tick counter, plus one long hold-off
  always @(negedge clk_i) begin
    stall_tick <= stall_tick + 1;
    if (hold_left > 0) begin
      hold_left--;
      out_stall_i <= 1'b1;
    end else if (!hold_done && words_taken >= 150) begin
      hold_done = 1'b1;
      hold_left = 400;
      out_stall_i <= 1'b1;
    end else begin
      case (stall_tick[8:7])
        2'd0: out_stall_i <= 1'b0;
        2'd1: out_stall_i <= ($urandom_range(0, 1) == 1);
        2'd2: out_stall_i <= ($urandom_range(0, 4) != 0);
        default: out_stall_i <= (stall_tick[1:0] != 2'd0);
      endcase
    end
  end

  // watchdog
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count >= CycleLimit) begin
      $display("** steiner_topology_from_split_vector: FAILED **");
      $finish;
    end
  end

  // reset, stimulus phases and final verdict
  initial begin
    repeat (2) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // smallest path with site extremes
    push_word(0, 0, 0, 1'b0);
    push_word(1, 63, 31, 1'b0);
    push_word(2, 0, 17, 1'b1);
    // short paths: last word on the root and on level 1, then level 2 again
    push_word(0, 0, 31, 1'b1);
    push_word(1, 0, 0, 1'b1);
    push_word(2, 63, 9, 1'b1);
    // split past the built edges, the first edge, the newest edge, a level resent
    push_word(0, 0, 1, 1'b0);
    push_word(1, 0, 2, 1'b0);
    push_word(2, 0, 3, 1'b0);
    push_word(3, 63, 31, 1'b0);
    push_word(4, 0, 0, 1'b0);
    push_word(4, 5, 30, 1'b0);
    push_word(5, 6, 4, 1'b0);
    push_word(6, 8, 5, 1'b1);
    // levels out of order, reusing what the stores hold
    push_word(5, 1, 29, 1'b0);
    push_word(3, 2, 28, 1'b0);
    push_word(6, 63, 27, 1'b1);

    run_phase(PhaseWords, 1'b1);

    // site count sweep, register written only while idle
    cfg_plan[5] = 6'($urandom_range(0, 63));
    foreach (cfg_plan[p]) begin
      settle();
      @(negedge clk_i);
      cfg_wdata_i = cfg_plan[p];
      cfg_we_i = 1'b1;
      @(negedge clk_i);
      cfg_we_i = 1'b0;
      run_phase(PhaseWords, cfg_plan[p] == stv_pkg::MinSites);
    end

    settle();
    if (mismatch_count == 0 && rows_due.size() == 0) begin
      $display("** steiner_topology_from_split_vector: PASSED **");
    end else begin
      $display("** steiner_topology_from_split_vector: FAILED **");
    end
    $finish;
  end

endmodule
